>>> rtl/dclim_pkg.sv
// shared types and constants for the drive current power limiter
`timescale 1ns / 1ps
package dclim_pkg;

	// item shape
	localparam int MOTOR_COUNT = 4;
	localparam int CUR_W       = 16;
	localparam int MAG_W       = 16;
	localparam int PWR_W       = 10;
	localparam int BUF_W       = 10;
	localparam int SUM_W       = MAG_W + $clog2(MOTOR_COUNT);

	// robot factor in units of 1/20, energy limit in units of 1/160
	localparam int F_W  = 7;
	localparam int L_W  = 21;
	localparam int FL_W = F_W + L_W;

	// scale = floor(F * L * 512 / (25 * sum)), clamped to one in Q1.16
	localparam int NUM_SHIFT = 9;
	localparam int NUM_W     = FL_W + NUM_SHIFT;
	localparam int DEN_W     = SUM_W + 5;
	localparam int DIV_STEPS = 16;
	localparam int SCALE_W   = DIV_STEPS + 1;
	localparam int PROD_W    = MAG_W + SCALE_W;

	// register stages: three front, one setup, quotient steps, scale, product, output
	localparam int LATENCY = 3 + 1 + DIV_STEPS + 3;

	localparam logic [PWR_W-1:0]   PWR_HIGH      = PWR_W'(100);
	localparam logic [PWR_W-1:0]   PWR_LOW       = PWR_W'(60);
	localparam logic [PWR_W-1:0]   PWR_OFFSET    = PWR_W'(20);
	localparam logic [F_W-1:0]     FACTOR_HIGH   = F_W'(80);
	localparam logic [F_W-1:0]     FACTOR_LOW    = F_W'(40);
	localparam logic [BUF_W-1:0]   BUF_FULL      = BUF_W'(800);
	localparam logic [BUF_W-1:0]   BUF_EMPTY     = BUF_W'(80);
	localparam logic [L_W-1:0]     LIMIT_FULL    = L_W'(8192 * 160);
	localparam logic [L_W-1:0]     ENERGY_SLOPE  = L_W'(1798);
	localparam logic [L_W-1:0]     ENERGY_OFFSET = L_W'(127680);
	localparam logic [DEN_W-1:0]   DEN_MULT      = DEN_W'(25);
	localparam logic [SCALE_W-1:0] SCALE_ONE     = SCALE_W'(65536);
	localparam logic [PWR_W-1:0]   PWR_RESET     = PWR_W'(60);

	typedef logic [NUM_W-1:0]   num_t;
	typedef logic [DEN_W-1:0]   den_t;
	typedef logic [SCALE_W-1:0] scale_t;

	// per-item data that rides along with the quotient
	typedef struct packed {
		logic [MOTOR_COUNT-1:0][MAG_W-1:0] mag;
		logic [MOTOR_COUNT-1:0]            neg;
	} side_t;

endpackage

>>> rtl/dclim_div.sv
// pipelined restoring divider producing the clamped Q1.16 scale
`timescale 1ns / 1ps
module dclim_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  dclim_pkg::num_t num,
	input  dclim_pkg::den_t den,
	input  dclim_pkg::side_t side_in,
	output logic            out_valid,
	output dclim_pkg::scale_t scale,
	output dclim_pkg::side_t side_out
);
	import dclim_pkg::*;

	localparam int LO_W = DIV_STEPS;

	logic                   step_valid_s [0:DIV_STEPS];
	logic [DEN_W-1:0]       step_rem_s   [0:DIV_STEPS];
	logic [DEN_W-1:0]       step_den_s   [0:DIV_STEPS];
	logic [LO_W-1:0]        step_lo_s    [0:DIV_STEPS];
	logic [DIV_STEPS-1:0]   step_quo_s   [0:DIV_STEPS];
	logic                   step_sat_s   [0:DIV_STEPS];
	side_t                  step_side_s  [0:DIV_STEPS];

	logic                   out_valid_q;
	scale_t                 scale_q;
	side_t                  side_q;

	logic [NUM_W+DEN_W-1:0] den_wide;
	logic [NUM_W+DEN_W-1:0] num_wide;

	// saturation check: quotient reaches one when num >= den * 2^16
	assign den_wide = (NUM_W + DEN_W)'({den, {DIV_STEPS{1'b0}}});
	assign num_wide = (NUM_W + DEN_W)'(num);

	// setup stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_valid_s[0] <= 1'b0;
		end else begin
			step_valid_s[0] <= in_valid;
		end
	end

	// setup stage payload: top bits of num seed the remainder
	always_ff @(posedge clk) begin
		step_sat_s[0]  <= num_wide >= den_wide;
		step_rem_s[0]  <= DEN_W'(num[NUM_W-1:LO_W]);
		step_lo_s[0]   <= num[LO_W-1:0];
		step_den_s[0]  <= den;
		step_quo_s[0]  <= '0;
		step_side_s[0] <= side_in;
	end

	// one quotient bit per stage
	for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
		logic [DEN_W:0] trial;
		logic           fits;

		assign trial = {step_rem_s[i], step_lo_s[i][LO_W-1-i]};
		assign fits  = trial >= {1'b0, step_den_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				step_valid_s[i+1] <= 1'b0;
			end else begin
				step_valid_s[i+1] <= step_valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			step_rem_s[i+1]  <= fits ? DEN_W'(trial - {1'b0, step_den_s[i]})
			                         : DEN_W'(trial);
			step_quo_s[i+1]  <= {step_quo_s[i][DIV_STEPS-2:0], fits};
			step_lo_s[i+1]   <= step_lo_s[i];
			step_den_s[i+1]  <= step_den_s[i];
			step_sat_s[i+1]  <= step_sat_s[i];
			step_side_s[i+1] <= step_side_s[i];
		end
	end

	// clamp to one and register the scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= step_valid_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		scale_q <= step_sat_s[DIV_STEPS] ? SCALE_ONE
		                                 : {1'b0, step_quo_s[DIV_STEPS]};
		side_q  <= step_side_s[DIV_STEPS];
	end

	assign out_valid = out_valid_q;
	assign scale     = scale_q;
	assign side_out  = side_q;

endmodule

>>> rtl/drive_current_power_limiter_core.sv
// top level of the drive current power limiter
`timescale 1ns / 1ps
// Scales four motor current commands so their summed magnitude stays within a
// budget set by the power limit register and the buffer energy of each item.
// The block takes a new item on every clock (busy never rises) and shows each
// result on the result ports for exactly one cycle, marked by result_valid;
// the receiver must capture it then. Each item passes through three front
// stages, a setup stage, the 16-stage quotient pipeline that forms the scale
// and three stages for the scale, product and output.
// The power limit port is always ready and should be written only while no
// item is in flight.
module drive_current_power_limiter_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [dclim_pkg::PWR_W-1:0]   cfg_data,
	input  logic                          start,
	output logic                          busy,
	input  logic [dclim_pkg::BUF_W-1:0]   buffer_energy,
	input  logic signed [dclim_pkg::CUR_W-1:0] current_0,
	input  logic signed [dclim_pkg::CUR_W-1:0] current_1,
	input  logic signed [dclim_pkg::CUR_W-1:0] current_2,
	input  logic signed [dclim_pkg::CUR_W-1:0] current_3,
	output logic                          result_valid,
	output logic signed [dclim_pkg::CUR_W-1:0] scaled_current_0,
	output logic signed [dclim_pkg::CUR_W-1:0] scaled_current_1,
	output logic signed [dclim_pkg::CUR_W-1:0] scaled_current_2,
	output logic signed [dclim_pkg::CUR_W-1:0] scaled_current_3,
	output logic [dclim_pkg::SCALE_W-1:0] scale_factor
);
	import dclim_pkg::*;

	logic [PWR_W-1:0]                  power_limit_q;
	logic                              accept;

	logic [MOTOR_COUNT-1:0][CUR_W-1:0] cur;
	side_t                             side_d;
	logic [F_W-1:0]                    factor_d;
	logic [L_W-1:0]                    limit_d;

	logic                              valid_s1;
	side_t                             side_s1;
	logic [F_W-1:0]                    factor_s1;
	logic [L_W-1:0]                    limit_s1;

	logic [SUM_W-1:0]                  sum_d;
	logic                              valid_s2;
	side_t                             side_s2;
	logic [SUM_W-1:0]                  sum_s2;
	logic [FL_W-1:0]                   fl_s2;

	logic                              valid_s3;
	side_t                             side_s3;
	num_t                              num_s3;
	den_t                              den_s3;

	logic                              div_valid;
	scale_t                            div_scale;
	side_t                             div_side;

	logic                              valid_s4;
	logic [MOTOR_COUNT-1:0]            neg_s4;
	logic [MOTOR_COUNT-1:0][PROD_W-1:0] prod_s4;
	scale_t                            scale_s4;

	logic                              valid_s5;
	logic [MOTOR_COUNT-1:0][CUR_W-1:0] out_s5;
	scale_t                            scale_s5;

	// always ready on both channels
	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;
	assign accept    = start && !busy;

	// power limit register, written on a cfg transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_limit_q <= PWR_RESET;
		end else if (cfg_valid && cfg_ready) begin
			power_limit_q <= cfg_data;
		end
	end

	// front stage: magnitudes, signs, robot factor and energy limit
	assign cur[0] = current_0;
	assign cur[1] = current_1;
	assign cur[2] = current_2;
	assign cur[3] = current_3;

	always_comb begin
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			side_d.neg[i] = cur[i][CUR_W-1];
			side_d.mag[i] = cur[i][CUR_W-1] ? MAG_W'(~cur[i] + 1'b1) : MAG_W'(cur[i]);
		end

		priority if (power_limit_q > PWR_HIGH) begin
			factor_d = FACTOR_HIGH;
		end else if (power_limit_q >= PWR_LOW) begin
			factor_d = F_W'(power_limit_q - PWR_OFFSET);
		end else begin
			factor_d = FACTOR_LOW;
		end

		priority if (buffer_energy > BUF_FULL) begin
			limit_d = LIMIT_FULL;
		end else if (buffer_energy > BUF_EMPTY) begin
			limit_d = ENERGY_SLOPE * L_W'(buffer_energy) - ENERGY_OFFSET;
		end else begin
			limit_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		side_s1   <= side_d;
		factor_s1 <= factor_d;
		limit_s1  <= limit_d;
	end

	// second stage: magnitude sum and factor times limit
	always_comb begin
		sum_d = '0;
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			sum_d = sum_d + SUM_W'(side_s1.mag[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		side_s2 <= side_s1;
		sum_s2  <= sum_d;
		fl_s2   <= FL_W'(factor_s1) * FL_W'(limit_s1);
	end

	// third stage: divider operands
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		side_s3 <= side_s2;
		num_s3  <= {fl_s2, {NUM_SHIFT{1'b0}}};
		den_s3  <= DEN_MULT * DEN_W'(sum_s2);
	end

	// quotient pipeline; a zero sum saturates to one
	dclim_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.num       (num_s3),
		.den       (den_s3),
		.side_in   (side_s3),
		.out_valid (div_valid),
		.scale     (div_scale),
		.side_out  (div_side)
	);

	// product stage: magnitude times scale
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= div_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			prod_s4[i] <= PROD_W'(div_side.mag[i]) * PROD_W'(div_scale);
		end
		neg_s4   <= div_side.neg;
		scale_s4 <= div_scale;
	end

	// output stage: drop fraction bits and restore the sign
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < MOTOR_COUNT; i++) begin
			out_s5[i] <= neg_s4[i] ? CUR_W'(~prod_s4[i][DIV_STEPS +: CUR_W] + 1'b1)
			                       : prod_s4[i][DIV_STEPS +: CUR_W];
		end
		scale_s5 <= scale_s4;
	end

	assign result_valid     = valid_s5;
	assign scaled_current_0 = out_s5[0];
	assign scaled_current_1 = out_s5[1];
	assign scaled_current_2 = out_s5[2];
	assign scaled_current_3 = out_s5[3];
	assign scale_factor     = scale_s5;

endmodule

>>> rtl/dclim_chk.sv
// port-level checker for the drive current power limiter, bound to the top level
`timescale 1ns / 1ps
module dclim_chk (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic signed [dclim_pkg::CUR_W-1:0]  current_0,
	input logic signed [dclim_pkg::CUR_W-1:0]  current_1,
	input logic                                result_valid,
	input logic signed [dclim_pkg::CUR_W-1:0]  scaled_current_0,
	input logic signed [dclim_pkg::CUR_W-1:0]  scaled_current_1,
	input logic [dclim_pkg::SCALE_W-1:0]       scale_factor
);
	import dclim_pkg::*;

	// a result only follows an item taken a fixed latency earlier
	a_result_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(start && !busy, LATENCY))
		else $error("result strobe without a matching start");

	// the scale never exceeds one
	a_scale_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> scale_factor <= SCALE_ONE)
		else $error("scale factor above one");

	// a scale of one passes currents 0 and 1 unchanged
	a_unity_pass: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && scale_factor == SCALE_ONE |->
		scaled_current_0 == $past(current_0, LATENCY) &&
		scaled_current_1 == $past(current_1, LATENCY))
		else $error("unity scale altered a current");

	// a zero scale clears currents 0 and 1
	a_zero_scale: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && scale_factor == '0 |->
		scaled_current_0 == '0 && scaled_current_1 == '0)
		else $error("zero scale left a current nonzero");

endmodule

bind drive_current_power_limiter_core dclim_chk u_dclim_chk (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.current_0        (current_0),
	.current_1        (current_1),
	.result_valid     (result_valid),
	.scaled_current_0 (scaled_current_0),
	.scaled_current_1 (scaled_current_1),
	.scale_factor     (scale_factor)
);

>>> sim/drive_current_power_limiter_core_tb.sv
// self-checking testbench for the drive current power limiter core
`timescale 1ns / 1ps
module drive_current_power_limiter_core_tb;

	localparam int MOTORS  = dclim_pkg::MOTOR_COUNT;
	localparam int CUR_W   = dclim_pkg::CUR_W;
	localparam int BUF_W   = dclim_pkg::BUF_W;
	localparam int PWR_W   = dclim_pkg::PWR_W;
	localparam int SCALE_W = dclim_pkg::SCALE_W;
	localparam int LATENCY = dclim_pkg::LATENCY;

	localparam int PHASES         = 8;
	localparam int SETS_PER_PHASE = 250;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PRINT_CAP      = 60;

	// one set of requests and one set of limited currents
	typedef struct packed {
		logic [BUF_W-1:0]                  buffer_energy;
		logic [MOTORS-1:0][CUR_W-1:0]      cur;
	} request_set_t;

	typedef struct packed {
		logic [MOTORS-1:0][CUR_W-1:0]      cur;
		logic [SCALE_W-1:0]                scale;
	} limited_set_t;

	typedef struct packed {
		request_set_t                      req;
		logic                              known;
		limited_set_t                      result;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [PWR_W-1:0] cfg_data;
	logic start;
	logic busy;
	logic [BUF_W-1:0] buffer_energy;
	logic signed [CUR_W-1:0] current_0, current_1, current_2, current_3;
	logic result_valid;
	logic signed [CUR_W-1:0] scaled_current_0, scaled_current_1;
	logic signed [CUR_W-1:0] scaled_current_2, scaled_current_3;
	logic [SCALE_W-1:0] scale_factor;

	// limits mirrored from the register, expectations waiting for their result
	logic [PWR_W-1:0] limit_mirror = 10'd60;
	limited_set_t     pending_sets[$];
	table_row_t       stimulus_table[$];

	// known answer that travels with the set being driven
	logic             drive_known;
	limited_set_t     drive_expected;

	int sets_taken      = 0;
	int results_checked = 0;
	int cfg_writes      = 0;
	int mismatches      = 0;
	int idle_cycles     = 0;

	drive_current_power_limiter_core u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.cfg_data         (cfg_data),
		.start            (start),
		.busy             (busy),
		.buffer_energy    (buffer_energy),
		.current_0        (current_0),
		.current_1        (current_1),
		.current_2        (current_2),
		.current_3        (current_3),
		.result_valid     (result_valid),
		.scaled_current_0 (scaled_current_0),
		.scaled_current_1 (scaled_current_1),
		.scaled_current_2 (scaled_current_2),
		.scaled_current_3 (scaled_current_3),
		.scale_factor     (scale_factor)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// budget from power limit and buffer energy, then scale each request
	function automatic limited_set_t limit_currents(logic [PWR_W-1:0] plimit,
			request_set_t req);
		longint unsigned factor;
		longint unsigned energy;
		longint unsigned total;
		longint unsigned scale;
		longint unsigned mag;
		longint unsigned prod;
		int              c;
		logic            neg;
		logic [CUR_W-1:0] q16;
		limited_set_t    res;
		// robot factor in 1/20 units
		if (plimit > 10'd100)
			factor = 80;
		else if (plimit >= 10'd60)
			factor = longint'(plimit) - 20;
		else
			factor = 40;
		// energy limit in 1/160 units
		if (req.buffer_energy > 10'd800)
			energy = 64'd1310720;
		else if (req.buffer_energy > 10'd80)
			energy = 64'd1798 * longint'(req.buffer_energy) - 64'd127680;
		else
			energy = 0;
		total = 0;
		for (int i = 0; i < MOTORS; i++) begin
			c = $signed(req.cur[i]);
			total += (c < 0) ? longint'(-c) : longint'(c);
		end
		// Q1.16 scale, one when nothing is requested
		if (total == 0) begin
			scale = 65536;
		end else begin
			scale = (factor * energy * 64'd65536) / (64'd3200 * total);
			if (scale > 65536)
				scale = 65536;
		end
		for (int i = 0; i < MOTORS; i++) begin
			c = $signed(req.cur[i]);
			neg = (c < 0);
			mag = neg ? longint'(-c) : longint'(c);
			prod = (mag * scale) >> 16;
			q16 = CUR_W'(prod);
			res.cur[i] = neg ? (~q16 + 1'b1) : q16;
		end
		res.scale = SCALE_W'(scale);
		return res;
	endfunction

	// one line per mismatch, printing capped
	task automatic note_mismatch(string msg);
		if (mismatches < PRINT_CAP)
			$display("[%0t] mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_limited(limited_set_t got, limited_set_t want);
		for (int i = 0; i < MOTORS; i++) begin
			if (got.cur[i] !== want.cur[i])
				note_mismatch($sformatf("result %0d scaled_current_%0d got %0d want %0d",
					results_checked, i, $signed(got.cur[i]), $signed(want.cur[i])));
		end
		if (got.scale !== want.scale)
			note_mismatch($sformatf("result %0d scale_factor got %0d want %0d",
				results_checked, got.scale, want.scale));
	endtask

	// results, register transfers and accepted sets, in that order
	always @(posedge clk) begin
		limited_set_t got;
		request_set_t req;
		if (arst_n) begin
			if (result_valid) begin
				got.cur[0] = scaled_current_0;
				got.cur[1] = scaled_current_1;
				got.cur[2] = scaled_current_2;
				got.cur[3] = scaled_current_3;
				got.scale  = scale_factor;
				if (pending_sets.size() == 0)
					note_mismatch($sformatf("unexpected result, scale_factor %0d", scale_factor));
				else
					check_limited(got, pending_sets.pop_front());
				results_checked++;
			end
			if (cfg_valid && cfg_ready) begin
				limit_mirror = cfg_data;
				cfg_writes++;
			end
			if (start && !busy) begin
				req.buffer_energy = buffer_energy;
				req.cur[0] = current_0;
				req.cur[1] = current_1;
				req.cur[2] = current_2;
				req.cur[3] = current_3;
				pending_sets.push_back(drive_known ? drive_expected :
					limit_currents(limit_mirror, req));
				sets_taken++;
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transfer for %0d cycles, %0d results outstanding",
					idle_cycles, pending_sets.size());
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	// directed rows: known answers where they are obvious, else predicted
	task automatic add_row(int b, int c0, int c1, int c2, int c3, bit known = 1'b0,
			int e0 = 0, int e1 = 0, int e2 = 0, int e3 = 0, int es = 0);
		table_row_t row;
		row.req.buffer_energy = BUF_W'(b);
		row.req.cur[0] = CUR_W'(c0);
		row.req.cur[1] = CUR_W'(c1);
		row.req.cur[2] = CUR_W'(c2);
		row.req.cur[3] = CUR_W'(c3);
		row.known = known;
		row.result.cur[0] = CUR_W'(e0);
		row.result.cur[1] = CUR_W'(e1);
		row.result.cur[2] = CUR_W'(e2);
		row.result.cur[3] = CUR_W'(e3);
		row.result.scale  = SCALE_W'(es);
		stimulus_table.push_back(row);
	endtask

	// random set weighted toward the interesting energy bands and magnitudes
	function automatic request_set_t random_set();
		request_set_t req;
		int mode;
		case ($urandom_range(9))
			0, 1:    req.buffer_energy = BUF_W'($urandom_range(80));
			2, 3, 4, 5: req.buffer_energy = BUF_W'($urandom_range(800, 81));
			6, 7:    req.buffer_energy = BUF_W'($urandom_range(1023, 801));
			8: begin
				case ($urandom_range(5))
					0: req.buffer_energy = 10'd0;
					1: req.buffer_energy = 10'd80;
					2: req.buffer_energy = 10'd81;
					3: req.buffer_energy = 10'd800;
					4: req.buffer_energy = 10'd801;
					default: req.buffer_energy = 10'd1023;
				endcase
			end
			default: req.buffer_energy = BUF_W'($urandom);
		endcase
		mode = $urandom_range(9);
		for (int i = 0; i < MOTORS; i++) begin
			case ((mode >= 8) ? int'($urandom_range(6)) : mode)
				0, 1, 2, 3: req.cur[i] = CUR_W'($urandom);
				4, 5: begin
					req.cur[i] = CUR_W'($urandom_range(255));
					if ($urandom_range(1))
						req.cur[i] = ~req.cur[i] + 1'b1;
				end
				6: begin
					case ($urandom_range(4))
						0: req.cur[i] = 16'h8000;
						1: req.cur[i] = 16'h7fff;
						2: req.cur[i] = 16'hffff;
						3: req.cur[i] = 16'h0001;
						default: req.cur[i] = 16'h0000;
					endcase
				end
				default: req.cur[i] = '0;
			endcase
		end
		return req;
	endfunction

	// present one set and hold it until the transfer
	task automatic send_set(request_set_t req, logic known, limited_set_t want);
		int taken_before;
		taken_before   = sets_taken;
		start          = 1'b1;
		buffer_energy  = req.buffer_energy;
		current_0      = req.cur[0];
		current_1      = req.cur[1];
		current_2      = req.cur[2];
		current_3      = req.cur[3];
		drive_known    = known;
		drive_expected = want;
		do @(negedge clk); while (sets_taken == taken_before);
	endtask

	// idle with start low and noise on the fields
	task automatic idle_gap(int n);
		request_set_t noise;
		noise         = random_set();
		start         = 1'b0;
		drive_known   = 1'b0;
		buffer_energy = noise.buffer_energy;
		current_0     = noise.cur[0];
		current_1     = noise.cur[1];
		current_2     = noise.cur[2];
		current_3     = noise.cur[3];
		repeat (n) @(negedge clk);
	endtask

	task automatic maybe_idle(int pct);
		int n;
		n = 0;
		while (int'($urandom_range(99)) < pct)
			n++;
		if (n > 0)
			idle_gap(n);
	endtask

	// stop sending and let every set in flight come out
	task automatic settle();
		idle_gap(1);
		while (pending_sets.size() != 0)
			@(negedge clk);
		repeat (LATENCY + 2) @(negedge clk);
	endtask

	task automatic write_power_limit(logic [PWR_W-1:0] value);
		int writes_before;
		writes_before = cfg_writes;
		cfg_valid = 1'b1;
		cfg_data  = value;
		do @(negedge clk); while (cfg_writes == writes_before);
		cfg_valid = 1'b0;
	endtask

	initial begin
		logic [PWR_W-1:0] phase_limits[PHASES];
		int               idle_pct[3];
		limited_set_t     none;
		int               table_sets;

		arst_n         = 1'b0;
		cfg_valid      = 1'b0;
		cfg_data       = '0;
		start          = 1'b0;
		buffer_energy  = '0;
		current_0      = '0;
		current_1      = '0;
		current_2      = '0;
		current_3      = '0;
		drive_known    = 1'b0;
		drive_expected = '0;
		none           = '0;

		// reset power limit is 60 W, factor 2.0
		add_row(0,    0, 0, 0, 0,                 1'b1, 0, 0, 0, 0, 65536);
		add_row(1023, 0, 0, 0, 0,                 1'b1, 0, 0, 0, 0, 65536);
		add_row(0,    100, -200, 300, -400,       1'b1, 0, 0, 0, 0, 0);
		add_row(80,   32767, -32768, 1, -1,       1'b1, 0, 0, 0, 0, 0);
		add_row(81,   1000, -1000, 1000, -1000);
		add_row(800,  32767, 32767, 32767, 32767);
		add_row(801,  -32768, -32768, -32768, -32768,
			1'b1, -4096, -4096, -4096, -4096, 8192);
		add_row(1023, -32768, -32768, -32768, -32768,
			1'b1, -4096, -4096, -4096, -4096, 8192);
		add_row(1023, 1, 0, 0, 0,                 1'b1, 1, 0, 0, 0, 65536);
		add_row(1023, 0, 0, 0, -1,                1'b1, 0, 0, 0, -1, 65536);
		add_row(1023, -32768, 0, 0, 0,            1'b1, -16384, 0, 0, 0, 32768);
		add_row(1023, 32767, 32767, 32767, 32767);
		add_row(1023, 32767, -32768, 16'h5555, -16'sh5556);
		add_row(400,  16'h00ff, -256, 16'h0f0f, -3856);
		add_row(512,  12345, -23456, 3456, -456);
		add_row(511,  -1, 2, -3, 4);
		add_row(682,  21845, -21846, 10922, -10923);
		add_row(341,  -7, 7000, -700, 70);

		phase_limits = '{10'd1023, 10'd0, 10'd59, 10'd100, 10'd101, 10'd60,
			PWR_W'($urandom_range(1023)), 10'd80};
		idle_pct = '{0, 81, 7};

		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// table walk
		table_sets = stimulus_table.size();
		foreach (stimulus_table[r]) begin
			send_set(stimulus_table[r].req, stimulus_table[r].known, stimulus_table[r].result);
			maybe_idle(30);
		end

		// one phase per power limit, rotating the sender idle mix
		for (int p = 0; p < PHASES; p++) begin
			settle();
			write_power_limit(phase_limits[p]);
			for (int k = 0; k < SETS_PER_PHASE; k++) begin
				send_set(random_set(), 1'b0, none);
				maybe_idle(idle_pct[p % 3]);
			end
		end
		settle();

		$display("covered %0d current sets (%0d directed) across %0d power limit writes",
			sets_taken, table_sets, cfg_writes);
		$display("checked %0d results field by field, %0d mismatches",
			results_checked, mismatches);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> files.f
rtl/dclim_pkg.sv
rtl/dclim_div.sv
rtl/drive_current_power_limiter_core.sv
rtl/dclim_chk.sv
sim/drive_current_power_limiter_core_tb.sv
